// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Shared counter type and training helpers, result record and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  // Default widths of the chooser index and of the global and local histories.
  localparam int unsigned CHOOSER_INDEX_BITS_DEF  = 10;
  localparam int unsigned GLOBAL_HISTORY_BITS_DEF = 10;
  localparam int unsigned LOCAL_HISTORY_BITS_DEF  = 10;

  // Two-bit saturating counter.
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN       = 2'd0;
  localparam ctr_t CTR_MAX       = 2'd3;
  localparam ctr_t CTR_STEP      = 2'd1;
  localparam ctr_t CTR_TAKEN_MIN = 2'd2;

  // Result queue: it must hold every request that can be in flight.
  localparam int unsigned OUT_FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned OCC_W          = $clog2(OUT_FIFO_DEPTH + 1);

  typedef struct packed {
    logic final_taken;
    logic private_taken;
    logic global_taken;
    logic chose_global;
    logic mispredicted;
  } res_t;

  function automatic ctr_t sat_train(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? c : c + CTR_STEP;
    end else begin
      r = (c == CTR_MIN) ? c : c - CTR_STEP;
    end
    return r;
  endfunction

  function automatic logic ctr_taken(ctr_t c);
    return (c >= CTR_TAKEN_MIN);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tournament_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local-history and gshare predictors, trained on every resolved branch, with
// a per-PC chooser that learns only when the two predictors disagree.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  ------------------------------------
//   in       in_valid_i / in_stall_o    pc_i, taken_i
//   out      out_valid_o / out_stall_i  final_taken_o, private_taken_o,
//                                       global_taken_o, chose_global_o,
//                                       mispredicted_o
//
// One request is accepted per clock while in_stall_o is low. Its result passes
// through history read, counter read, then write-back and queueing before it
// is offered.
// After reset every table is swept to zero, one entry per cycle, over
// 2**max(index widths) addresses (1024 at the defaults), with in_stall_o high.
// Results wait in a four-entry queue; in_stall_o rises when four requests are
// accepted and not yet delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor import tbp_pkg::*; #(
  parameter int unsigned CHOOSER_INDEX_BITS  = CHOOSER_INDEX_BITS_DEF,
  parameter int unsigned GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF,
  parameter int unsigned LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] pc_i,
  input  wire logic        taken_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             final_taken_o,
  output logic             private_taken_o,
  output logic             global_taken_o,
  output logic             chose_global_o,
  output logic             mispredicted_o
);

  localparam int unsigned LB = LOCAL_HISTORY_BITS;
  localparam int unsigned GB = GLOBAL_HISTORY_BITS;
  localparam int unsigned CB = CHOOSER_INDEX_BITS;
  localparam int unsigned LG_MAX = (LB > GB) ? LB : GB;
  localparam int unsigned CLR_W  = (LG_MAX > CB) ? LG_MAX : CB;

  // --------------------------------------------------------------------------
  // Handshake and clearing sweep
  // --------------------------------------------------------------------------
  logic             accept;
  logic             pop;
  logic             clear_q;
  logic [CLR_W-1:0] clr_cnt_q;
  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_d;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = clear_q || (occ_q == OCC_W'(OUT_FIFO_DEPTH));
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      if (clr_cnt_q == '1) begin
        clear_q <= 1'b0;
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (!accept && pop) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // --------------------------------------------------------------------------
  // Global history, updated as each request is accepted
  // --------------------------------------------------------------------------
  logic [GB-1:0] ghr_q;
  logic [GB:0]   ghr_shift;

  assign ghr_shift = {ghr_q, taken_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghr_q <= '0;
    end else if (accept) begin
      ghr_q <= ghr_shift[GB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: local history read returns, local counter index formed
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [LB-1:0] s1_lh_idx_q;
  logic [GB-1:0] s1_gc_idx_q;
  logic [CB-1:0] s1_ch_idx_q;
  logic          s1_taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lh_idx_q <= pc_i[LB-1:0];
      s1_gc_idx_q <= ghr_q ^ pc_i[GB-1:0];
      s1_ch_idx_q <= pc_i[CB-1:0];
      s1_taken_q  <= taken_i;
    end
  end

  logic [LB-1:0] lh_rdata;
  logic [LB-1:0] lh_cur;
  logic [LB:0]   lh_shift;
  logic [LB-1:0] lc_idx;
  logic          lh_we;
  logic [LB-1:0] lh_waddr;
  logic [LB-1:0] lh_wdata;
  logic          lhb_valid_q;
  logic [LB-1:0] lhb_addr_q;
  logic [LB-1:0] lhb_data_q;

  // The table RAMs read old data on a same-cycle write, so the write made at
  // the read edge is held in a bypass register and forwarded.
  assign lh_cur   = (lhb_valid_q && (lhb_addr_q == s1_lh_idx_q)) ? lhb_data_q : lh_rdata;
  assign lh_shift = {lh_cur, s1_taken_q};
  assign lc_idx   = lh_cur ^ s1_lh_idx_q;

  always_comb begin
    lh_we    = s1_valid_q;
    lh_waddr = s1_lh_idx_q;
    lh_wdata = lh_shift[LB-1:0];
    if (clear_q) begin
      lh_we    = ((clr_cnt_q >> LB) == '0);
      lh_waddr = clr_cnt_q[LB-1:0];
      lh_wdata = '0;
    end
  end

  tbp_ram #(
    .WIDTH (LB),
    .DEPTH (1 << LB)
  ) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .re_i    (accept),
    .raddr_i (pc_i[LB-1:0]),
    .rdata_o (lh_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 2: counters return, predictions, training
  // --------------------------------------------------------------------------
  logic          s2_valid_q;
  logic [LB-1:0] s2_lc_idx_q;
  logic [GB-1:0] s2_gc_idx_q;
  logic [CB-1:0] s2_ch_idx_q;
  logic          s2_taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_lc_idx_q <= lc_idx;
      s2_gc_idx_q <= s1_gc_idx_q;
      s2_ch_idx_q <= s1_ch_idx_q;
      s2_taken_q  <= s1_taken_q;
    end
  end

  ctr_t          lc_rdata, gc_rdata, ch_rdata;
  ctr_t          lc_ctr, gc_ctr, ch_ctr;
  logic          p_pred, g_pred, use_g, fin;
  logic          lc_we, gc_we, ch_we;
  logic [LB-1:0] lc_waddr;
  logic [GB-1:0] gc_waddr;
  logic [CB-1:0] ch_waddr;
  ctr_t          lc_wdata, gc_wdata, ch_wdata;
  logic          lcb_valid_q, gcb_valid_q, chb_valid_q;
  logic [LB-1:0] lcb_addr_q;
  logic [GB-1:0] gcb_addr_q;
  logic [CB-1:0] chb_addr_q;
  ctr_t          lcb_data_q, gcb_data_q, chb_data_q;

  assign lc_ctr = (lcb_valid_q && (lcb_addr_q == s2_lc_idx_q)) ? lcb_data_q : lc_rdata;
  assign gc_ctr = (gcb_valid_q && (gcb_addr_q == s2_gc_idx_q)) ? gcb_data_q : gc_rdata;
  assign ch_ctr = (chb_valid_q && (chb_addr_q == s2_ch_idx_q)) ? chb_data_q : ch_rdata;

  assign p_pred = ctr_taken(lc_ctr);
  assign g_pred = ctr_taken(gc_ctr);
  assign use_g  = ctr_taken(ch_ctr);
  assign fin    = use_g ? g_pred : p_pred;

  always_comb begin
    lc_we    = s2_valid_q;
    lc_waddr = s2_lc_idx_q;
    lc_wdata = sat_train(lc_ctr, s2_taken_q);
    gc_we    = s2_valid_q;
    gc_waddr = s2_gc_idx_q;
    gc_wdata = sat_train(gc_ctr, s2_taken_q);
    // The chooser only learns when the two predictors disagree.
    ch_we    = s2_valid_q && (p_pred != g_pred);
    ch_waddr = s2_ch_idx_q;
    ch_wdata = sat_train(ch_ctr, g_pred == s2_taken_q);
    if (clear_q) begin
      lc_we    = ((clr_cnt_q >> LB) == '0);
      lc_waddr = clr_cnt_q[LB-1:0];
      lc_wdata = CTR_MIN;
      gc_we    = ((clr_cnt_q >> GB) == '0);
      gc_waddr = clr_cnt_q[GB-1:0];
      gc_wdata = CTR_MIN;
      ch_we    = ((clr_cnt_q >> CB) == '0);
      ch_waddr = clr_cnt_q[CB-1:0];
      ch_wdata = CTR_MIN;
    end
  end

  tbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (1 << LB)
  ) u_lc_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .re_i    (s1_valid_q),
    .raddr_i (lc_idx),
    .rdata_o (lc_rdata)
  );

  tbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (1 << GB)
  ) u_gc_ram (
    .clk_i   (clk_i),
    .we_i    (gc_we),
    .waddr_i (gc_waddr),
    .wdata_i (gc_wdata),
    .re_i    (s1_valid_q),
    .raddr_i (s1_gc_idx_q),
    .rdata_o (gc_rdata)
  );

  tbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (1 << CB)
  ) u_ch_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (s1_valid_q),
    .raddr_i (s1_ch_idx_q),
    .rdata_o (ch_rdata)
  );

  // Bypass registers: the last write of each table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhb_valid_q <= 1'b0;
      lcb_valid_q <= 1'b0;
      gcb_valid_q <= 1'b0;
      chb_valid_q <= 1'b0;
    end else begin
      lhb_valid_q <= lh_we;
      lcb_valid_q <= lc_we;
      gcb_valid_q <= gc_we;
      chb_valid_q <= ch_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lh_we) begin
      lhb_addr_q <= lh_waddr;
      lhb_data_q <= lh_wdata;
    end
    if (lc_we) begin
      lcb_addr_q <= lc_waddr;
      lcb_data_q <= lc_wdata;
    end
    if (gc_we) begin
      gcb_addr_q <= gc_waddr;
      gcb_data_q <= gc_wdata;
    end
    if (ch_we) begin
      chb_addr_q <= ch_waddr;
      chb_data_q <= ch_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  res_t                  fifo_q [OUT_FIFO_DEPTH];
  res_t                  push_res;
  res_t                  head;
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [OCC_W-1:0]      fifo_cnt_q;
  logic [OCC_W-1:0]      fifo_cnt_d;

  assign push_res = '{
    final_taken:   fin,
    private_taken: p_pred,
    global_taken:  g_pred,
    chose_global:  use_g,
    mispredicted:  fin != s2_taken_q
  };

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (s2_valid_q && !pop) begin
      fifo_cnt_d = fifo_cnt_q + OCC_W'(1);
    end else if (!s2_valid_q && pop) begin
      fifo_cnt_d = fifo_cnt_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (s2_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign out_valid_o     = (fifo_cnt_q != '0);
  assign final_taken_o   = head.final_taken;
  assign private_taken_o = head.private_taken;
  assign global_taken_o  = head.global_taken;
  assign chose_global_o  = head.chose_global;
  assign mispredicted_o  = head.mispredicted;

endmodule

`default_nettype wire

// ===== rtl/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// Tournament branch predictor table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tbp_checker.sv =====
// ----------------------------------------------------------------------------
// Tournament branch predictor checker
// Port-level properties of the predictor, attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_checker import tbp_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [31:0] pc_i,
  input wire logic        taken_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        final_taken_o,
  input wire logic        private_taken_o,
  input wire logic        global_taken_o,
  input wire logic        chose_global_o,
  input wire logic        mispredicted_o
);

  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Requests accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + OCC_W'(1);
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - OCC_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable({final_taken_o,
      private_taken_o, global_taken_o, chose_global_o, mispredicted_o})))
    else $error("stalled result changed or was dropped");

  a_final_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (final_taken_o == (chose_global_o ? global_taken_o : private_taken_o)))
    else $error("final prediction does not follow the chooser");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != '0))
    else $error("result offered with no request pending");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (pend_q != OCC_W'(OUT_FIFO_DEPTH)))
    else $error("request accepted with the result queue committed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (pend_q == '0)) |-> ##3 out_valid_o)
    else $error("result of an idle-pipe request did not appear in time");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);

`default_nettype wire
